// ===== design/fmre_pkg.sv =====
// ----------------------------------------------------------------------------
// fmre_pkg
// shared constants and types of the factor model rmse evaluator
// ----------------------------------------------------------------------------
package fmre_pkg;

    localparam int MAX_RANK    = 64;
    localparam int MAX_ENTRIES = 1048576;
    // entry counter is 21 bits wide, so the cap never exceeds its range
    localparam int ENTRY_CAP   = (MAX_ENTRIES < 2097151) ? MAX_ENTRIES : 2097151;

    localparam int ELEM_W  = 16;
    localparam int RANK_W  = 7;
    localparam int RMSE_W  = 20;
    localparam int ENTRY_W = 21;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;

    localparam logic [RANK_W-1:0] RANK_RESET = 7'd8;

    // command to the divide / square root unit
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   dividend;
        logic [ENTRY_W-1:0] divisor;
    } t_ds_cmd;

    // result of the divide / square root unit
    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_ds_result;

endpackage

// ===== design/fmre_in_if.sv =====
// ----------------------------------------------------------------------------
// fmre_in_if
// input channel: one factor pair with rating and set marker per transaction
// ----------------------------------------------------------------------------
interface fmre_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [fmre_pkg::ELEM_W-1:0]  w_element;
    logic signed [fmre_pkg::ELEM_W-1:0]  h_element;
    logic signed [fmre_pkg::ELEM_W-1:0]  rating;
    logic                                last_entry;

    modport source (output valid, w_element, h_element, rating, last_entry, input ready);
    modport sink   (input valid, w_element, h_element, rating, last_entry, output ready);

endinterface

// ===== design/fmre_out_if.sv =====
// ----------------------------------------------------------------------------
// fmre_out_if
// result channel: rmse of one closed set per transaction
// ----------------------------------------------------------------------------
interface fmre_out_if;

    logic                          valid;
    logic                          ready;
    logic [fmre_pkg::RMSE_W-1:0]   rmse_value;
    logic [fmre_pkg::ENTRY_W-1:0]  entry_total;
    logic                          saturated;

    modport source (output valid, rmse_value, entry_total, saturated, input ready);
    modport sink   (input valid, rmse_value, entry_total, saturated, output ready);

endinterface

// ===== design/factor_model_rmse_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// factor_model_rmse_evaluator_top
// scores a factor model on test ratings: dot product per entry, squared
// rounded error summed over the set, rmse = isqrt(sum / entries) in Q8.12
// ----------------------------------------------------------------------------
//
//  channel    direction  transaction carries
//  ---------  ---------  ----------------------------------------------------
//  i_in_item  in         w_element, h_element, rating, last_entry (Q4.12)
//  o_result   out        rmse_value (Q8.12), entry_total, saturated
//  apb        in         rank_in_use at byte address 0
//
//  a pair that does not complete an entry passes accept and accumulate
//  a pair that completes an entry passes accept, accumulate, error, square,
//  sum; closing a set then runs the divide / root unit
//  (64 divide steps + 32 root steps on one shared subtractor)
//  reset is synchronous, active low; it clears the set state and loads rank 8
//  one waiting result is held in the output register; input is accepted only
//  in the idle state, so it also stalls while a finished set waits to load it
//
module factor_model_rmse_evaluator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fmre_in_if.sink            i_in_item,
    fmre_out_if.source         o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_ERR   = 3'd2;
    localparam logic [2:0] S_SQ    = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_START = 3'd5;
    localparam logic [2:0] S_ROOT  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic REG_RANK = 1'b0;

    // effective rank: zero acts as one, above the maximum acts as the maximum
    function automatic logic [fmre_pkg::RANK_W-1:0] eff_rank(
        input logic [fmre_pkg::RANK_W-1:0] r
    );
        logic [fmre_pkg::RANK_W-1:0] v;
        if (r == '0) begin
            v = 7'd1;
        end else if (int'(r) > fmre_pkg::MAX_RANK) begin
            v = 7'(fmre_pkg::MAX_RANK);
        end else begin
            v = r;
        end
        return v;
    endfunction

    logic [2:0]                           r_state;
    logic [fmre_pkg::RANK_W-1:0]          r_rank;

    // set state
    logic signed [31:0]                   r_dot;
    logic [fmre_pkg::RANK_W-1:0]          r_term;
    logic [fmre_pkg::SUM_W-1:0]           r_sum;
    logic [fmre_pkg::ENTRY_W-1:0]         r_entry;
    logic                                 r_sat_seen;

    // per transaction payload
    logic signed [31:0]                   r_prod;
    logic signed [fmre_pkg::ELEM_W-1:0]   r_rating;
    logic                                 r_last;
    logic signed [20:0]                   r_q;
    logic [41:0]                          r_sq;

    // output register
    logic                                 r_out_valid;
    logic [fmre_pkg::RMSE_W-1:0]          r_out_rmse;
    logic [fmre_pkg::ENTRY_W-1:0]         r_out_total;
    logic                                 r_out_sat;

    logic                                 in_fire;
    logic                                 out_free;
    logic                                 cfg_write;
    logic [32:0]                          acc_sum;
    logic                                 acc_ovf;
    logic signed [31:0]                   acc_sat;
    logic [fmre_pkg::RANK_W-1:0]          term_next;
    logic signed [33:0]                   err_rnd;
    logic [fmre_pkg::SUM_W:0]             sum_next;
    logic signed [41:0]                   sq_full;
    logic                                 root_big;

    fmre_pkg::t_ds_cmd                    ds_cmd;
    fmre_pkg::t_ds_result                 ds_result;

    assign in_fire   = i_in_item.valid && i_in_item.ready;
    assign out_free  = !r_out_valid || o_result.ready;
    assign cfg_write = psel && penable && pwrite;

    assign i_in_item.ready = (r_state == S_IDLE);

    // saturating dot accumulation
    always_comb begin
        acc_sum   = 33'({r_dot[31], r_dot} + {r_prod[31], r_prod});
        acc_ovf   = (acc_sum[32] != acc_sum[31]);
        acc_sat   = acc_ovf ? (acc_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff)
                            : signed'(acc_sum[31:0]);
        term_next = r_term + 7'd1;
    end

    // error = dot - rating * 4096, rounded half up to Q.12
    always_comb begin
        err_rnd = 34'({{2{r_dot[31]}}, r_dot})
                - 34'({{6{r_rating[15]}}, r_rating, 12'd0})
                + 34'sd2048;
    end

    always_comb begin
        sq_full  = r_q * r_q;
        sum_next = {1'b0, r_sum} + {23'd0, r_sq};
        root_big = (ds_result.root[fmre_pkg::ROOT_W-1:fmre_pkg::RMSE_W] != '0);
    end

    assign ds_cmd.start    = (r_state == S_START);
    assign ds_cmd.dividend = r_sum;
    assign ds_cmd.divisor  = r_entry;

    fmre_divsqrt u_divsqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ds_cmd),
        .o_result (ds_result)
    );

    // sequencer and set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dot      <= '0;
            r_term     <= '0;
            r_sum      <= '0;
            r_entry    <= '0;
            r_sat_seen <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_dot <= acc_sat;
                    if (acc_ovf) begin
                        r_sat_seen <= 1'b1;
                    end
                    r_term <= term_next;
                    // rank can drop mid entry, so compare with >=
                    r_state <= (term_next >= eff_rank(r_rank)) ? S_ERR : S_IDLE;
                end
                S_ERR: begin
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_entry >= fmre_pkg::ENTRY_W'(fmre_pkg::ENTRY_CAP)) begin
                        r_sat_seen <= 1'b1;
                    end else begin
                        if (sum_next[fmre_pkg::SUM_W]) begin
                            r_sum      <= '1;
                            r_sat_seen <= 1'b1;
                        end else begin
                            r_sum <= sum_next[fmre_pkg::SUM_W-1:0];
                        end
                        r_entry <= r_entry + 21'd1;
                    end
                    r_dot   <= '0;
                    r_term  <= '0;
                    r_state <= r_last ? S_START : S_IDLE;
                end
                S_START: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (ds_result.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_sum      <= '0;
                        r_entry    <= '0;
                        r_sat_seen <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // transaction payload capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_prod   <= i_in_item.w_element * i_in_item.h_element;
            r_rating <= i_in_item.rating;
            r_last   <= i_in_item.last_entry;
        end
        if (r_state == S_ERR) begin
            r_q <= err_rnd[32:12];
        end
        if (r_state == S_SQ) begin
            r_sq <= unsigned'(sq_full);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_rmse  <= root_big ? '1 : ds_result.root[fmre_pkg::RMSE_W-1:0];
            r_out_total <= r_entry;
            r_out_sat   <= r_sat_seen || root_big;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.rmse_value  = r_out_rmse;
    assign o_result.entry_total = r_out_total;
    assign o_result.saturated   = r_out_sat;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= fmre_pkg::RANK_RESET;
        end else if (cfg_write && paddr[2] == REG_RANK) begin
            r_rank <= pwdata[fmre_pkg::RANK_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_RANK) ? {25'd0, r_rank} : 32'd0;
    assign pready = 1'b1;

endmodule

// ===== design/fmre_divsqrt.sv =====
// ----------------------------------------------------------------------------
// fmre_divsqrt
// restoring divide of the square sum by the entry count, then digit-by-digit
// integer square root of the quotient, both on one shared subtractor
// ----------------------------------------------------------------------------
module fmre_divsqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fmre_pkg::t_ds_cmd    i_cmd,
    output fmre_pkg::t_ds_result o_result
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DIV  = 2'd1;
    localparam logic [1:0] PH_SQRT = 2'd2;

    localparam int OP_W = 36;

    logic [1:0]                    r_phase;
    logic [5:0]                    r_cnt;
    logic                          r_done;
    logic [fmre_pkg::SUM_W-1:0]    r_quo;
    logic [33:0]                   r_rem;
    logic [fmre_pkg::ENTRY_W-1:0]  r_div;
    logic [fmre_pkg::ROOT_W-1:0]   r_root;

    logic [OP_W-1:0] sub_a;
    logic [OP_W-1:0] sub_b;
    logic [OP_W:0]   sub_diff;
    logic            sub_ge;

    // operand select for the shared subtractor
    always_comb begin
        if (r_phase == PH_SQRT) begin
            sub_a = {r_rem, r_quo[63:62]};
            sub_b = {2'b00, r_root, 2'b01};
        end else begin
            sub_a = {14'd0, r_rem[20:0], r_quo[63]};
            sub_b = {15'd0, r_div};
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[OP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 6'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_cmd.start) begin
                        r_phase <= PH_DIV;
                        r_cnt   <= 6'd0;
                    end
                end
                PH_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_phase <= PH_SQRT;
                        r_cnt   <= 6'd0;
                    end
                end
                PH_SQRT: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.start) begin
                    r_quo <= i_cmd.dividend;
                    r_div <= i_cmd.divisor;
                    r_rem <= 34'd0;
                end
            end
            PH_DIV: begin
                r_quo <= {r_quo[62:0], sub_ge};
                if (r_cnt == 6'd63) begin
                    // root digits start from a clean remainder
                    r_rem  <= 34'd0;
                    r_root <= '0;
                end else begin
                    r_rem <= sub_ge ? {13'd0, sub_diff[20:0]} : {13'd0, sub_a[20:0]};
                end
            end
            PH_SQRT: begin
                // two quotient bits per root digit
                r_quo  <= {r_quo[61:0], 2'b00};
                r_rem  <= sub_ge ? sub_diff[33:0] : sub_a[33:0];
                r_root <= {r_root[30:0], sub_ge};
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_result.done = r_done;
    assign o_result.root = r_root;

endmodule
